// ===== rtl/dra_pkg.sv =====
// Shared types, constants and helpers of the DNS reply address extractor.
// No dependencies; every other file but dra_ram imports this package.
package dra_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_BYTES_DEF   = 64;
    localparam int ANSWER_SLOTS_DEF = 4;
    localparam int MAX_JUMPS_DEF    = 16;

    // Name lengths never exceed 63, slot counts never exceed 7.
    localparam int LEN_W  = 6;
    localparam int SLOT_W = 3;
    // Wide enough for any offset plus a 16-bit length plus the fixed parts.
    localparam int CALC_W = 18;

    localparam int HEADER_BYTES = 12;
    localparam int RR_FIXED     = 10;
    localparam int Q_TAIL       = 4;

    localparam logic [1:0] KIND_QNAME  = 2'd0;
    localparam logic [1:0] KIND_ANAME  = 2'd1;
    localparam logic [1:0] KIND_REC    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0]  LAB_PTR    = 2'b11;
    localparam logic [15:0] QR_BIT     = 16'h8000;
    localparam logic [15:0] RCODE_MASK = 16'h000F;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_AAAA  = 16'd28;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] RDLEN_A    = 16'd4;
    localparam logic [15:0] RDLEN_AAAA = 16'd16;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;

    localparam logic [2:0] FAM_V4 = 3'd4;
    localparam logic [2:0] FAM_V6 = 3'd6;

    typedef struct packed {
        logic              fail;
        logic [SLOT_W-1:0] total;
        logic [15:0]       dropped;
        logic [LEN_W-1:0]  qlen;
    } job_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ===== rtl/dns_reply_address_extractor.sv =====
// Top level of the DNS reply address extractor: front parser, job queue, emitter.
// Depends on dra_pkg, dra_ram, dra_front, dra_jobq, dra_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | pkt_byte, end_of_packet
//  out     | out_valid / out_ready  | kind, answer_index, chars, char_count,
//          |                        | addr_family, ttl, addr_high, addr_low,
//          |                        | dropped, answer_total, status, last
//
// Bytes load at one per cycle into the packet RAM while in_ready is high. After
// the end beat the front parses from that RAM once the emitter is idle: header
// fetch, each label with its characters, pointers, record headers and stored
// address bytes; input stays stalled until it is done. The emitter packs name
// characters into beats, then a record beat per stored answer and a status beat.
// Reset is asynchronous; stores need no clearing pass. Either side may stall freely.
module dns_reply_address_extractor
    import dra_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = NAME_BYTES_DEF,
    parameter int ANSWER_SLOTS = ANSWER_SLOTS_DEF,
    parameter int MAX_JUMPS    = MAX_JUMPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pkt_byte,
    input  logic        end_of_packet,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [1:0]  answer_index,
    output logic [63:0] chars,
    output logic [3:0]  char_count,
    output logic [2:0]  addr_family,
    output logic [31:0] ttl,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low,
    output logic [15:0] dropped,
    output logic [2:0]  answer_total,
    output logic        status,
    output logic        last
);

    localparam int QAW = $clog2(NAME_BYTES);
    localparam int TAW = $clog2(ANSWER_SLOTS * NAME_BYTES);

    logic             back_idle, q_full, q_avail, q_pop, job_push;
    job_t             job_data, q_head;
    logic             qt_we, at_we;
    logic [QAW-1:0]   qt_waddr, qt_raddr;
    logic [TAW-1:0]   at_waddr, at_raddr;
    logic [7:0]       t_wdata, qt_rdata, at_rdata;
    logic [LEN_W-1:0] alen [ANSWER_SLOTS];
    logic [31:0]      slot_ttl [ANSWER_SLOTS];
    logic [63:0]      slot_hi [ANSWER_SLOTS];
    logic [63:0]      slot_lo [ANSWER_SLOTS];
    logic             slot_v6 [ANSWER_SLOTS];

    dra_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .NAME_BYTES   (NAME_BYTES),
        .ANSWER_SLOTS (ANSWER_SLOTS),
        .MAX_JUMPS    (MAX_JUMPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt_byte      (pkt_byte),
        .end_of_packet (end_of_packet),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .back_idle     (back_idle),
        .q_full        (q_full),
        .job_push      (job_push),
        .job_data      (job_data),
        .qt_we         (qt_we),
        .qt_waddr      (qt_waddr),
        .at_we         (at_we),
        .at_waddr      (at_waddr),
        .t_wdata       (t_wdata),
        .alen_reg      (alen),
        .ttl_reg       (slot_ttl),
        .hi_reg        (slot_hi),
        .lo_reg        (slot_lo),
        .v6_reg        (slot_v6)
    );

    dra_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_qtext (
        .clk   (clk),
        .we    (qt_we),
        .waddr (qt_waddr),
        .wdata (t_wdata),
        .raddr (qt_raddr),
        .rdata (qt_rdata)
    );

    dra_ram #(.WIDTH(8), .DEPTH(ANSWER_SLOTS * NAME_BYTES)) u_atext (
        .clk   (clk),
        .we    (at_we),
        .waddr (at_waddr),
        .wdata (t_wdata),
        .raddr (at_raddr),
        .rdata (at_rdata)
    );

    dra_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_data),
        .pop       (q_pop),
        .avail     (q_avail),
        .full      (q_full),
        .head      (q_head)
    );

    dra_back #(
        .NAME_BYTES   (NAME_BYTES),
        .ANSWER_SLOTS (ANSWER_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_avail      (q_avail),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .back_idle    (back_idle),
        .qt_raddr     (qt_raddr),
        .qt_rdata     (qt_rdata),
        .at_raddr     (at_raddr),
        .at_rdata     (at_rdata),
        .alen         (alen),
        .ttl_in       (slot_ttl),
        .hi_in        (slot_hi),
        .lo_in        (slot_lo),
        .v6_in        (slot_v6),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .answer_index (answer_index),
        .chars        (chars),
        .char_count   (char_count),
        .addr_family  (addr_family),
        .ttl          (ttl),
        .addr_high    (addr_high),
        .addr_low     (addr_low),
        .dropped      (dropped),
        .answer_total (answer_total),
        .status       (status),
        .last         (last)
    );

endmodule

// ===== rtl/dra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dra_front.sv =====
// Front part: loads packet bytes, parses header, names and records, fills slots.
// Depends on dra_pkg and dra_ram (packet buffer).
module dra_front
    import dra_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = NAME_BYTES_DEF,
    parameter int ANSWER_SLOTS = ANSWER_SLOTS_DEF,
    parameter int MAX_JUMPS    = MAX_JUMPS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [7:0]                                  pkt_byte,
    input  logic                                        end_of_packet,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        back_idle,
    input  logic                                        q_full,
    output logic                                        job_push,
    output job_t                                        job_data,
    output logic                                        qt_we,
    output logic [$clog2(NAME_BYTES)-1:0]               qt_waddr,
    output logic                                        at_we,
    output logic [$clog2(ANSWER_SLOTS*NAME_BYTES)-1:0]  at_waddr,
    output logic [7:0]                                  t_wdata,
    output logic [LEN_W-1:0]                            alen_reg [ANSWER_SLOTS],
    output logic [31:0]                                 ttl_reg  [ANSWER_SLOTS],
    output logic [63:0]                                 hi_reg   [ANSWER_SLOTS],
    output logic [63:0]                                 lo_reg   [ANSWER_SLOTS],
    output logic                                        v6_reg   [ANSWER_SLOTS]
);

    localparam int AW  = $clog2(PACKET_BYTES);
    localparam int PW  = $clog2(PACKET_BYTES + 1);
    localparam int JW  = $clog2(MAX_JUMPS + 2);
    localparam int QAW = $clog2(NAME_BYTES);
    localparam int TAW = $clog2(ANSWER_SLOTS * NAME_BYTES);
    localparam int SIW = (ANSWER_SLOTS > 1) ? $clog2(ANSWER_SLOTS) : 1;

    typedef enum logic [14:0] {
        F_LOAD   = 15'b000000000000001,
        F_WAIT   = 15'b000000000000010,
        F_GET    = 15'b000000000000100,
        F_HDR    = 15'b000000000001000,
        F_NSTART = 15'b000000000010000,
        F_NLAB   = 15'b000000000100000,
        F_NPTR   = 15'b000000001000000,
        F_NCHR   = 15'b000000010000000,
        F_QTAIL  = 15'b000000100000000,
        F_ANS    = 15'b000001000000000,
        F_RHDR0  = 15'b000010000000000,
        F_RHDR   = 15'b000100000000000,
        F_RDAT   = 15'b001000000000000,
        F_DONE   = 15'b010000000000000,
        F_FAIL   = 15'b100000000000000
    } fstate_t;

    fstate_t           state_reg, state_next;
    fstate_t           get_ret_reg, get_ret_next;
    fstate_t           name_ret_reg, name_ret_next;
    logic [PW-1:0]     cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     ra_reg, ra_next;
    logic [127:0]      acc_reg, acc_next;
    logic [4:0]        getn_reg, getn_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [5:0]        lab_reg, lab_next;
    logic [5:0]        chn_reg, chn_next;
    logic [LEN_W-1:0]  w_reg, w_next;
    logic [JW-1:0]     jumps_reg, jumps_next;
    logic              jumped_reg, jumped_next;
    logic [PW-1:0]     nxt_reg, nxt_next;
    logic [PW-1:0]     off_reg, off_next;
    logic [15:0]       an_reg, an_next;
    logic [15:0]       ai_reg, ai_next;
    logic [SLOT_W-1:0] stored_reg, stored_next;
    logic [15:0]       drop_reg, drop_next;
    logic              v6p_reg, v6p_next;
    logic [31:0]       ttlp_reg, ttlp_next;
    logic              nameq_reg, nameq_next;
    logic [LEN_W-1:0]  qlen_reg, qlen_next;

    logic              pw_en;
    logic [7:0]        rdata;
    logic              tw_en;
    logic [7:0]        tw_data;
    logic              slot_we;

    logic [CALC_W-1:0] c_len, c_pos1, c_wdot, c_dend, c_tgt;
    logic              dot;
    logic [15:0]       f_type, f_cls, f_rdl;
    logic              match;

    dra_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
        .clk   (clk),
        .we    (pw_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (pkt_byte),
        .raddr (ra_next),
        .rdata (rdata)
    );

    assign in_ready = (state_reg == F_LOAD);

    assign c_len  = CALC_W'(cnt_reg);
    assign c_pos1 = CALC_W'(pos_reg) + CALC_W'(1);
    assign dot    = (w_reg != '0);
    assign c_wdot = CALC_W'(w_reg) + CALC_W'(dot);
    assign c_tgt  = CALC_W'({lab_reg, rdata});
    assign f_type = acc_reg[79:64];
    assign f_cls  = acc_reg[63:48];
    assign f_rdl  = acc_reg[15:0];
    assign c_dend = CALC_W'(off_reg) + CALC_W'(RR_FIXED) + CALC_W'(f_rdl);
    assign match  = (f_cls == CLASS_IN) &&
                    (((f_type == TYPE_A) && (f_rdl == RDLEN_A)) ||
                     ((f_type == TYPE_AAAA) && (f_rdl == RDLEN_AAAA)));

    assign qt_we    = tw_en && nameq_reg;
    assign qt_waddr = w_reg[QAW-1:0];
    assign at_we    = tw_en && !nameq_reg && (stored_reg < SLOT_W'(ANSWER_SLOTS));
    assign at_waddr = TAW'(int'(stored_reg) * NAME_BYTES + int'(w_reg));
    assign t_wdata  = tw_data;

    always_comb
    begin
        state_next    = state_reg;
        get_ret_next  = get_ret_reg;
        name_ret_next = name_ret_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        ra_next       = ra_reg;
        acc_next      = acc_reg;
        getn_next     = getn_reg;
        pos_next      = pos_reg;
        lab_next      = lab_reg;
        chn_next      = chn_reg;
        w_next        = w_reg;
        jumps_next    = jumps_reg;
        jumped_next   = jumped_reg;
        nxt_next      = nxt_reg;
        off_next      = off_reg;
        an_next       = an_reg;
        ai_next       = ai_reg;
        stored_next   = stored_reg;
        drop_next     = drop_reg;
        v6p_next      = v6p_reg;
        ttlp_next     = ttlp_reg;
        nameq_next    = nameq_reg;
        qlen_next     = qlen_reg;
        pw_en         = 1'b0;
        tw_en         = 1'b0;
        tw_data       = CHAR_DOT;
        slot_we       = 1'b0;
        job_push      = 1'b0;
        job_data      = '0;

        unique case (state_reg)
            F_LOAD:
            begin
                if (in_valid)
                begin
                    if (c_len < CALC_W'(PACKET_BYTES))
                    begin
                        pw_en    = 1'b1;
                        cnt_next = cnt_reg + PW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (end_of_packet)
                    begin
                        state_next = F_WAIT;
                    end
                end
            end
            F_WAIT:
            begin
                // slot storage and text RAMs belong to the back until it is done
                if (back_idle)
                begin
                    stored_next = '0;
                    drop_next   = '0;
                    if (ovf_reg || (c_len < CALC_W'(HEADER_BYTES)))
                    begin
                        state_next = F_FAIL;
                    end
                    else
                    begin
                        ra_next      = AW'(2);
                        getn_next    = 5'd6;
                        get_ret_next = F_HDR;
                        state_next   = F_GET;
                    end
                end
            end
            F_GET:
            begin
                acc_next  = {acc_reg[119:0], rdata};
                ra_next   = ra_reg + AW'(1);
                getn_next = getn_reg - 5'd1;
                if (getn_reg == 5'd1)
                begin
                    state_next = get_ret_reg;
                end
            end
            F_HDR:
            begin
                if (((acc_reg[47:32] & QR_BIT) == '0) ||
                    ((acc_reg[47:32] & RCODE_MASK) != '0) ||
                    (acc_reg[31:16] != 16'd1) || (acc_reg[15:0] == '0))
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    an_next       = acc_reg[15:0];
                    pos_next      = PW'(HEADER_BYTES);
                    w_next        = '0;
                    jumps_next    = '0;
                    jumped_next   = 1'b0;
                    nameq_next    = 1'b1;
                    name_ret_next = F_QTAIL;
                    state_next    = F_NSTART;
                end
            end
            F_NSTART:
            begin
                if (CALC_W'(pos_reg) >= c_len)
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    ra_next    = pos_reg[AW-1:0];
                    state_next = F_NLAB;
                end
            end
            F_NLAB:
            begin
                if (rdata[7:6] == LAB_PTR)
                begin
                    if (c_pos1 >= c_len)
                    begin
                        state_next = F_FAIL;
                    end
                    else
                    begin
                        lab_next   = rdata[5:0];
                        ra_next    = AW'(c_pos1);
                        state_next = F_NPTR;
                    end
                end
                else if (rdata[7:6] != 2'b00)
                begin
                    state_next = F_FAIL;
                end
                else if (rdata == 8'd0)
                begin
                    if (!jumped_reg)
                    begin
                        nxt_next = PW'(c_pos1);
                    end
                    state_next = name_ret_reg;
                end
                else if ((c_pos1 + CALC_W'(rdata[5:0]) > c_len) ||
                         (dot && (CALC_W'(w_reg) + CALC_W'(1) >= CALC_W'(NAME_BYTES))) ||
                         (c_wdot + CALC_W'(rdata[5:0]) >= CALC_W'(NAME_BYTES)))
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    tw_en      = dot;
                    tw_data    = CHAR_DOT;
                    w_next     = LEN_W'(c_wdot);
                    pos_next   = PW'(c_pos1);
                    ra_next    = AW'(c_pos1);
                    chn_next   = rdata[5:0];
                    state_next = F_NCHR;
                end
            end
            F_NPTR:
            begin
                if (!jumped_reg)
                begin
                    nxt_next = PW'(CALC_W'(pos_reg) + CALC_W'(2));
                end
                jumped_next = 1'b1;
                jumps_next  = jumps_reg + JW'(1);
                if ((jumps_reg + JW'(1) > JW'(MAX_JUMPS)) || (c_tgt >= CALC_W'(pos_reg)))
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    pos_next   = PW'(c_tgt);
                    state_next = F_NSTART;
                end
            end
            F_NCHR:
            begin
                tw_en    = 1'b1;
                tw_data  = to_lower(rdata);
                w_next   = w_reg + LEN_W'(1);
                pos_next = pos_reg + PW'(1);
                ra_next  = ra_reg + AW'(1);
                chn_next = chn_reg - 6'd1;
                if (chn_reg == 6'd1)
                begin
                    state_next = F_NSTART;
                end
            end
            F_QTAIL:
            begin
                qlen_next = w_reg;
                if (CALC_W'(nxt_reg) + CALC_W'(Q_TAIL) > c_len)
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    off_next   = PW'(CALC_W'(nxt_reg) + CALC_W'(Q_TAIL));
                    ai_next    = '0;
                    state_next = F_ANS;
                end
            end
            F_ANS:
            begin
                if (ai_reg == an_reg)
                begin
                    state_next = F_DONE;
                end
                else
                begin
                    pos_next      = off_reg;
                    w_next        = '0;
                    jumps_next    = '0;
                    jumped_next   = 1'b0;
                    nameq_next    = 1'b0;
                    name_ret_next = F_RHDR0;
                    state_next    = F_NSTART;
                end
            end
            F_RHDR0:
            begin
                if (CALC_W'(nxt_reg) + CALC_W'(RR_FIXED) > c_len)
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    off_next     = nxt_reg;
                    ra_next      = nxt_reg[AW-1:0];
                    getn_next    = 5'd10;
                    get_ret_next = F_RHDR;
                    state_next   = F_GET;
                end
            end
            F_RHDR:
            begin
                if (c_dend > c_len)
                begin
                    state_next = F_FAIL;
                end
                else
                begin
                    off_next   = PW'(c_dend);
                    ai_next    = ai_reg + 16'd1;
                    ttlp_next  = acc_reg[47:16];
                    state_next = F_ANS;
                    if (match && (stored_reg < SLOT_W'(ANSWER_SLOTS)))
                    begin
                        v6p_next     = (f_type == TYPE_AAAA);
                        ra_next      = AW'(CALC_W'(off_reg) + CALC_W'(RR_FIXED));
                        getn_next    = f_rdl[4:0];
                        get_ret_next = F_RDAT;
                        state_next   = F_GET;
                    end
                    else if (match && (drop_reg != 16'hFFFF))
                    begin
                        drop_next = drop_reg + 16'd1;
                    end
                end
            end
            F_RDAT:
            begin
                slot_we     = 1'b1;
                stored_next = stored_reg + SLOT_W'(1);
                state_next  = F_ANS;
            end
            F_DONE:
            begin
                job_push         = 1'b1;
                job_data.fail    = (stored_reg == '0);
                job_data.total   = stored_reg;
                job_data.dropped = drop_reg;
                job_data.qlen    = qlen_reg;
                cnt_next         = '0;
                ovf_next         = 1'b0;
                state_next       = F_LOAD;
            end
            F_FAIL:
            begin
                job_push      = 1'b1;
                job_data.fail = 1'b1;
                cnt_next      = '0;
                ovf_next      = 1'b0;
                state_next    = F_LOAD;
            end
            default:
            begin
                state_next = F_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_LOAD;
            get_ret_reg  <= F_HDR;
            name_ret_reg <= F_QTAIL;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            ra_reg       <= '0;
            getn_reg     <= '0;
            stored_reg   <= '0;
            drop_reg     <= '0;
            qlen_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            get_ret_reg  <= get_ret_next;
            name_ret_reg <= name_ret_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            ra_reg       <= ra_next;
            getn_reg     <= getn_next;
            stored_reg   <= stored_next;
            drop_reg     <= drop_next;
            qlen_reg     <= qlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        pos_reg    <= pos_next;
        lab_reg    <= lab_next;
        chn_reg    <= chn_next;
        w_reg      <= w_next;
        jumps_reg  <= jumps_next;
        jumped_reg <= jumped_next;
        nxt_reg    <= nxt_next;
        off_reg    <= off_next;
        an_reg     <= an_next;
        ai_reg     <= ai_next;
        v6p_reg    <= v6p_next;
        ttlp_reg   <= ttlp_next;
        nameq_reg  <= nameq_next;
        if (slot_we)
        begin
            alen_reg[stored_reg[SIW-1:0]] <= w_reg;
            ttl_reg[stored_reg[SIW-1:0]]  <= ttlp_reg;
            v6_reg[stored_reg[SIW-1:0]]   <= v6p_reg;
            hi_reg[stored_reg[SIW-1:0]]   <= v6p_reg ? acc_reg[127:64]
                                                     : {acc_reg[31:0], 32'd0};
            lo_reg[stored_reg[SIW-1:0]]   <= v6p_reg ? acc_reg[63:0] : 64'd0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("job pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (qt_we || at_we) |-> (state_reg == F_NCHR || state_reg == F_NLAB))
        else $error("text write outside name decode");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_GET) |-> (getn_reg != 5'd0))
        else $error("field fetch with zero count");

endmodule

// ===== rtl/dra_jobq.sv =====
// Two-entry queue of parse results between front and back.
// Depends on dra_pkg (job_t).
module dra_jobq
    import dra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output logic avail,
    output logic full,
    output job_t head
);

    job_t       ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign avail = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && avail)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && avail);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dra_back.sv =====
// Back part: turns a finished parse into result beats through an output register.
// Depends on dra_pkg; reads the text RAMs held at the top and the slot registers of the front.
module dra_back
    import dra_pkg::*;
#(
    parameter int NAME_BYTES   = NAME_BYTES_DEF,
    parameter int ANSWER_SLOTS = ANSWER_SLOTS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_avail,
    input  job_t                                        q_head,
    output logic                                        q_pop,
    output logic                                        back_idle,
    output logic [$clog2(NAME_BYTES)-1:0]               qt_raddr,
    input  logic [7:0]                                  qt_rdata,
    output logic [$clog2(ANSWER_SLOTS*NAME_BYTES)-1:0]  at_raddr,
    input  logic [7:0]                                  at_rdata,
    input  logic [LEN_W-1:0]                            alen [ANSWER_SLOTS],
    input  logic [31:0]                                 ttl_in [ANSWER_SLOTS],
    input  logic [63:0]                                 hi_in [ANSWER_SLOTS],
    input  logic [63:0]                                 lo_in [ANSWER_SLOTS],
    input  logic                                        v6_in [ANSWER_SLOTS],
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [1:0]                                  kind,
    output logic [1:0]                                  answer_index,
    output logic [63:0]                                 chars,
    output logic [3:0]                                  char_count,
    output logic [2:0]                                  addr_family,
    output logic [31:0]                                 ttl,
    output logic [63:0]                                 addr_high,
    output logic [63:0]                                 addr_low,
    output logic [15:0]                                 dropped,
    output logic [2:0]                                  answer_total,
    output logic                                        status,
    output logic                                        last
);

    localparam int QAW = $clog2(NAME_BYTES);
    localparam int TAW = $clog2(ANSWER_SLOTS * NAME_BYTES);
    localparam int SIW = (ANSWER_SLOTS > 1) ? $clog2(ANSWER_SLOTS) : 1;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_CHR   = 6'b000010,
        B_PUSH  = 6'b000100,
        B_NEXTA = 6'b001000,
        B_REC   = 6'b010000,
        B_STAT  = 6'b100000
    } bstate_t;

    bstate_t           state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [LEN_W-1:0]  ci_reg, ci_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [3:0]        ccnt_reg, ccnt_next;
    logic [63:0]       chunk_reg, chunk_next;
    logic              phq_reg, phq_next;
    logic              out_valid_reg;

    logic              out_free;
    logic              beat_load;
    logic [1:0]        b_kind, b_idx;
    logic [63:0]       b_chars, b_hi, b_lo;
    logic [3:0]        b_cnt;
    logic [2:0]        b_fam, b_total;
    logic [31:0]       b_ttl;
    logic [15:0]       b_drop;
    logic              b_status, b_last;
    logic [7:0]        rd;
    logic [SIW-1:0]    si;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign back_idle = (state_reg == B_IDLE) && !q_avail;
    assign rd        = phq_reg ? qt_rdata : at_rdata;
    assign si        = s_reg[SIW-1:0];
    // read address follows the next index so data always matches ci_reg
    assign qt_raddr  = ci_next[QAW-1:0];
    assign at_raddr  = TAW'(int'(s_next) * NAME_BYTES + int'(ci_next));

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        s_next     = s_reg;
        ci_next    = ci_reg;
        len_next   = len_reg;
        ccnt_next  = ccnt_reg;
        chunk_next = chunk_reg;
        phq_next   = phq_reg;
        q_pop      = 1'b0;
        beat_load  = 1'b0;
        b_kind     = KIND_STATUS;
        b_idx      = 2'd0;
        b_chars    = '0;
        b_cnt      = '0;
        b_fam      = '0;
        b_ttl      = '0;
        b_hi       = '0;
        b_lo       = '0;
        b_drop     = '0;
        b_total    = '0;
        b_status   = 1'b0;
        b_last     = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    s_next     = '0;
                    ci_next    = '0;
                    ccnt_next  = '0;
                    chunk_next = '0;
                    phq_next   = 1'b1;
                    len_next   = q_head.qlen;
                    if (q_head.fail)
                    begin
                        state_next = B_STAT;
                    end
                    else if (q_head.qlen == '0)
                    begin
                        phq_next   = 1'b0;
                        state_next = B_NEXTA;
                    end
                    else
                    begin
                        state_next = B_CHR;
                    end
                end
            end
            B_CHR:
            begin
                chunk_next[{ccnt_reg[2:0], 3'b000} +: 8] = rd;
                ci_next   = ci_reg + LEN_W'(1);
                ccnt_next = ccnt_reg + 4'd1;
                if ((ccnt_reg == 4'd7) || (ci_reg + LEN_W'(1) == len_reg))
                begin
                    state_next = B_PUSH;
                end
            end
            B_PUSH:
            begin
                if (out_free)
                begin
                    beat_load  = 1'b1;
                    b_kind     = phq_reg ? KIND_QNAME : KIND_ANAME;
                    b_idx      = s_reg[1:0];
                    b_chars    = chunk_reg;
                    b_cnt      = ccnt_reg;
                    ccnt_next  = '0;
                    chunk_next = '0;
                    if (ci_reg != len_reg)
                    begin
                        state_next = B_CHR;
                    end
                    else if (phq_reg)
                    begin
                        phq_next   = 1'b0;
                        ci_next    = '0;
                        state_next = B_NEXTA;
                    end
                    else
                    begin
                        state_next = B_REC;
                    end
                end
            end
            B_NEXTA:
            begin
                ci_next = '0;
                if (s_reg == job_reg.total)
                begin
                    state_next = B_STAT;
                end
                else
                begin
                    len_next   = alen[si];
                    ccnt_next  = '0;
                    chunk_next = '0;
                    state_next = (alen[si] == '0) ? B_REC : B_CHR;
                end
            end
            B_REC:
            begin
                if (out_free)
                begin
                    beat_load  = 1'b1;
                    b_kind     = KIND_REC;
                    b_idx      = s_reg[1:0];
                    b_fam      = v6_in[si] ? FAM_V6 : FAM_V4;
                    b_ttl      = ttl_in[si];
                    b_hi       = hi_in[si];
                    b_lo       = lo_in[si];
                    s_next     = s_reg + SLOT_W'(1);
                    ci_next    = '0;
                    state_next = B_NEXTA;
                end
            end
            B_STAT:
            begin
                if (out_free)
                begin
                    beat_load  = 1'b1;
                    b_kind     = KIND_STATUS;
                    b_last     = 1'b1;
                    b_status   = job_reg.fail;
                    b_drop     = job_reg.fail ? 16'd0 : job_reg.dropped;
                    b_total    = job_reg.fail ? 3'd0 : job_reg.total;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            s_reg         <= '0;
            ci_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            ci_reg    <= ci_next;
            if (beat_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        len_reg   <= len_next;
        ccnt_reg  <= ccnt_next;
        chunk_reg <= chunk_next;
        phq_reg   <= phq_next;
        if (beat_load)
        begin
            kind         <= b_kind;
            answer_index <= b_idx;
            chars        <= b_chars;
            char_count   <= b_cnt;
            addr_family  <= b_fam;
            ttl          <= b_ttl;
            addr_high    <= b_hi;
            addr_low     <= b_lo;
            dropped      <= b_drop;
            answer_total <= b_total;
            status       <= b_status;
            last         <= b_last;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        beat_load |-> ((b_kind == KIND_STATUS) == b_last))
        else $error("last flag not tied to status beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat_load && (b_kind == KIND_QNAME || b_kind == KIND_ANAME)) |->
        (b_cnt != 4'd0 && b_cnt <= 4'd8))
        else $error("name beat with bad char count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat_load && b_kind == KIND_REC) |-> (s_reg < job_reg.total))
        else $error("record beat beyond stored answers");

endmodule

// ===== bench/tb.sv =====
// Testbench for dns_reply_address_extractor: DNS replies, directed and random, in bytes.
// Needs dra_pkg and the RTL. A scoreboard class predicts each packet's output beats.
`timescale 1ns / 100ps

module tb;
    import dra_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  idx;
        logic [63:0] chars;
        logic [3:0]  cnt;
        logic [2:0]  fam;
        logic [31:0] ttl;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] drop;
        logic [2:0]  total;
        logic        status;
        logic        last;
    } reply_beat_t;

    class reply_scoreboard;
        logic [7:0]  mem[PACKET_BYTES_DEF];
        int          nbytes;
        bit          ovf;
        logic [7:0]  name_buf[NAME_BYTES_DEF];
        int          name_len;
        logic [7:0]  q_text[NAME_BYTES_DEF];
        int          q_len;
        logic [7:0]  slot_text[ANSWER_SLOTS_DEF][NAME_BYTES_DEF];
        int          slot_len[ANSWER_SLOTS_DEF];
        logic [63:0] slot_hi[ANSWER_SLOTS_DEF];
        logic [63:0] slot_lo[ANSWER_SLOTS_DEF];
        logic [31:0] slot_ttl[ANSWER_SLOTS_DEF];
        bit          slot_v6[ANSWER_SLOTS_DEF];
        int          stored;
        int          drops;
        reply_beat_t pending[$];
        int          errors;
        int          matched;
        int          packets;
        int          good_packets;

        function int get16(int p);
            return (int'(mem[p]) << 8) | int'(mem[p + 1]);
        endfunction

        // Walk one name into name_buf; nxt is the offset just past it in the record.
        function bit walk_name(input int start, output int nxt);
            int pos, w, jumps, lab, tgt;
            bit jumped;
            logic [7:0] c;
            pos = start;
            w = 0;
            jumps = 0;
            jumped = 0;
            nxt = start;
            while (1)
            begin
                if (pos >= nbytes) return 0;
                lab = mem[pos];
                if ((lab & 'hC0) == 'hC0)
                begin
                    if (pos + 1 >= nbytes) return 0;
                    tgt = ((lab & 'h3F) << 8) | int'(mem[pos + 1]);
                    if (!jumped)
                    begin
                        nxt = pos + 2;
                        jumped = 1;
                    end
                    jumps++;
                    if (jumps > MAX_JUMPS_DEF) return 0;
                    if (tgt >= pos) return 0;
                    pos = tgt;
                    continue;
                end
                if (lab & 'hC0) return 0;
                if (lab == 0)
                begin
                    if (!jumped) nxt = pos + 1;
                    name_len = w;
                    return 1;
                end
                pos++;
                if (pos + lab > nbytes) return 0;
                if (w != 0)
                begin
                    if (w + 1 >= NAME_BYTES_DEF) return 0;
                    name_buf[w] = CHAR_DOT;
                    w++;
                end
                if (w + lab >= NAME_BYTES_DEF) return 0;
                for (int i = 0; i < lab; i++)
                begin
                    c = mem[pos + i];
                    if (c >= "A" && c <= "Z") c = c + 8'd32;
                    name_buf[w] = c;
                    w++;
                end
                pos += lab;
            end
        endfunction

        function bit parse_reply();
            int flags, qd, an, off, typ, cls, rdlen, s;
            logic [31:0] life;
            logic [63:0] hi, lo;
            stored = 0;
            drops = 0;
            if (ovf || nbytes < HEADER_BYTES) return 0;
            flags = get16(2);
            if ((flags & QR_BIT) == 0) return 0;
            if ((flags & RCODE_MASK) != 0) return 0;
            qd = get16(4);
            an = get16(6);
            if (qd != 1 || an == 0) return 0;
            if (!walk_name(HEADER_BYTES, off)) return 0;
            q_text = name_buf;
            q_len = name_len;
            if (off + Q_TAIL > nbytes) return 0;
            off += Q_TAIL;
            for (int i = 0; i < an; i++)
            begin
                if (!walk_name(off, off)) return 0;
                if (off + RR_FIXED > nbytes) return 0;
                typ = get16(off);
                cls = get16(off + 2);
                life = (get16(off + 4) << 16) | get16(off + 6);
                rdlen = get16(off + 8);
                off += RR_FIXED;
                if (off + rdlen > nbytes) return 0;
                if (cls == CLASS_IN && ((typ == TYPE_A && rdlen == RDLEN_A) ||
                                        (typ == TYPE_AAAA && rdlen == RDLEN_AAAA)))
                begin
                    if (stored >= ANSWER_SLOTS_DEF)
                    begin
                        if (drops < 'hFFFF) drops++;
                    end
                    else
                    begin
                        s = stored;
                        stored++;
                        hi = '0;
                        lo = '0;
                        for (int k = 0; k < 8; k++)
                            hi = {hi[55:0], (k < rdlen) ? mem[off + k] : 8'h00};
                        for (int k = 8; k < 16; k++)
                            lo = {lo[55:0], (k < rdlen) ? mem[off + k] : 8'h00};
                        slot_text[s] = name_buf;
                        slot_len[s] = name_len;
                        slot_hi[s] = hi;
                        slot_lo[s] = lo;
                        slot_ttl[s] = life;
                        slot_v6[s] = (typ == TYPE_AAAA);
                    end
                end
                off += rdlen;
            end
            return stored != 0;
        endfunction

        function void queue_name(logic [1:0] kind, int idx, logic [7:0] txt[NAME_BYTES_DEF],
                                 int len);
            reply_beat_t b;
            int cnt;
            for (int c = 0; c < len; c += 8)
            begin
                b = '0;
                cnt = (len - c < 8) ? len - c : 8;
                for (int k = 0; k < cnt; k++) b.chars[8*k +: 8] = txt[c + k];
                b.kind = kind;
                b.idx = idx[1:0];
                b.cnt = cnt[3:0];
                pending.push_back(b);
            end
        endfunction

        function void note_byte(logic [7:0] data, logic eop);
            reply_beat_t b;
            if (nbytes < PACKET_BYTES_DEF)
            begin
                mem[nbytes] = data;
                nbytes++;
            end
            else
                ovf = 1;
            if (!eop) return;
            packets++;
            b = '0;
            if (parse_reply())
            begin
                good_packets++;
                queue_name(KIND_QNAME, 0, q_text, q_len);
                for (int s = 0; s < stored; s++)
                begin
                    reply_beat_t r;
                    queue_name(KIND_ANAME, s, slot_text[s], slot_len[s]);
                    r = '0;
                    r.kind = KIND_REC;
                    r.idx = s[1:0];
                    r.fam = slot_v6[s] ? FAM_V6 : FAM_V4;
                    r.ttl = slot_ttl[s];
                    r.hi = slot_hi[s];
                    r.lo = slot_lo[s];
                    pending.push_back(r);
                end
                b.drop = drops[15:0];
                b.total = stored[2:0];
            end
            else
                b.status = 1'b1;
            b.kind = KIND_STATUS;
            b.last = 1'b1;
            pending.push_back(b);
            nbytes = 0;
            ovf = 0;
        endfunction

        function void check_beat(reply_beat_t got);
            reply_beat_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS) $display("unexpected beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.idx !== want.idx || got.chars !== want.chars ||
                got.cnt !== want.cnt || got.fam !== want.fam || got.ttl !== want.ttl ||
                got.hi !== want.hi || got.lo !== want.lo || got.drop !== want.drop ||
                got.total !== want.total || got.status !== want.status ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch\n  expected %p\n  actual   %p", want, got);
            end
            else
                matched++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pkt_byte;
    logic        end_of_packet;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [1:0]  answer_index;
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic [2:0]  addr_family;
    logic [31:0] ttl;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] dropped;
    logic [2:0]  answer_total;
    logic        status;
    logic        last;

    reply_scoreboard sb;
    logic [7:0]  pkt[$];
    int          cycles;
    int          bytes_sent;
    bit          calm_in;
    bit          calm_out;
    bit          hold_req;

    dns_reply_address_extractor DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d beats outstanding",
                         cycles, sb.pending.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, one quiet window, one long hold-off.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm_out || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat({kind, answer_index, chars, char_count, addr_family, ttl,
                           addr_high, addr_low, dropped, answer_total, status, last});
        calm_out <= (cycles >= 1000 && cycles < 3000);
    end

    task send_beat(input logic [7:0] data, input logic eop);
        while (!calm_in && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pkt_byte <= data;
        end_of_packet <= eop;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(data, eop);
        bytes_sent++;
    endtask

    task send_packet();
        for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
    endtask

    task push16(input int v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    task start_reply(input int flags, input int qd, input int an);
        pkt.delete();
        push16($urandom);
        push16(flags);
        push16(qd);
        push16(an);
        push16($urandom_range(0, 3));
        push16($urandom_range(0, 3));
    endtask

    task push_label(input int len);
        int r;
        pkt.push_back(len[7:0]);
        repeat (len)
        begin
            r = $urandom_range(99);
            if (r < 40) pkt.push_back(8'("A" + $urandom_range(25)));
            else if (r < 85) pkt.push_back(8'("a" + $urandom_range(25)));
            else pkt.push_back(8'($urandom));
        end
    endtask

    task push_rand_name(input int max_labels);
        repeat ($urandom_range(0, max_labels)) push_label($urandom_range(1, 10));
        pkt.push_back(8'h00);
    endtask

    task push_question();
        push_rand_name(3);
        push16($urandom_range(1, 28));
        push16(CLASS_IN);
    endtask

    task push_record(input int typ, input int cls, input int rdlen);
        push16(typ);
        push16(cls);
        push16($urandom);
        push16($urandom);
        push16(rdlen);
        repeat (rdlen) pkt.push_back(8'($urandom));
    endtask

    task push_rand_answer();
        int r;
        r = $urandom_range(2);
        if (r == 0) push16(16'hC00C);
        else if (r == 1) push_rand_name(2);
        else
        begin
            push_label($urandom_range(1, 8));
            push16(16'hC00C);
        end
        r = $urandom_range(9);
        if (r < 4) push_record(TYPE_A, CLASS_IN, RDLEN_A);
        else if (r < 7) push_record(TYPE_AAAA, CLASS_IN, RDLEN_AAAA);
        else if (r == 7) push_record(TYPE_A, 3, RDLEN_A);
        else if (r == 8) push_record(99, CLASS_IN, $urandom_range(0, 8));
        else push_record(TYPE_A, CLASS_IN, 5);
    endtask

    // Chain of k backward pointers hidden in an ignored record, then an A answer
    // whose name walks the whole chain: k+1 jumps.
    task pointer_chain(input int k);
        start_reply(16'h8180, 1, 2);
        pkt.push_back(8'h00);
        push16(TYPE_A);
        push16(CLASS_IN);
        pkt.push_back(8'h00);
        push16(99);
        push16(CLASS_IN);
        push16(0);
        push16(0);
        push16(2 * k);
        for (int j = 0; j < k; j++) push16(j == 0 ? 16'hC00C : 16'hC000 | (28 + 2 * (j - 1)));
        push16(16'hC000 | (28 + 2 * (k - 1)));
        push_record(TYPE_A, CLASS_IN, RDLEN_A);
    endtask

    task long_question(input int l1, input int l2);
        start_reply(16'h8180, 1, 1);
        push_label(l1);
        push_label(l2);
        pkt.push_back(8'h00);
        push16(TYPE_A);
        push16(CLASS_IN);
        push16(16'hC00C);
        push_record(TYPE_A, CLASS_IN, RDLEN_A);
    endtask

    task directed();
        // plain A and AAAA replies
        start_reply(16'h8180, 1, 1);
        push_label(3);
        push_label(7);
        pkt.push_back(8'h00);
        push16(TYPE_A);
        push16(CLASS_IN);
        push16(16'hC00C);
        push_record(TYPE_A, CLASS_IN, RDLEN_A);
        send_packet();
        start_reply(16'hFFF0, 1, 1);
        push_question();
        push_rand_name(2);
        push_record(TYPE_AAAA, CLASS_IN, RDLEN_AAAA);
        send_packet();
        // root question name, answer owned by root too
        start_reply(16'h8180, 1, 1);
        pkt.push_back(8'h00);
        push16(TYPE_A);
        push16(CLASS_IN);
        pkt.push_back(8'h00);
        push_record(TYPE_A, CLASS_IN, RDLEN_A);
        send_packet();
        // short message
        pkt.delete();
        repeat (5) pkt.push_back(8'($urandom));
        send_packet();
        // header rejects: query, rcode, two questions, no answers
        start_reply(16'h0180, 1, 1);
        push_question();
        push_rand_answer();
        send_packet();
        start_reply(16'h8183, 1, 1);
        push_question();
        push_rand_answer();
        send_packet();
        start_reply(16'h8180, 2, 1);
        push_question();
        push_rand_answer();
        send_packet();
        start_reply(16'h8180, 1, 0);
        push_question();
        send_packet();
        // forward pointer, truncated pointer
        start_reply(16'h8180, 1, 1);
        push_question();
        push16(16'hC0FF);
        push_record(TYPE_A, CLASS_IN, RDLEN_A);
        send_packet();
        start_reply(16'h8180, 1, 1);
        push_question();
        pkt.push_back(8'hC0);
        send_packet();
        // jump limit: exactly at it, then one over
        pointer_chain(MAX_JUMPS_DEF - 1);
        send_packet();
        pointer_chain(MAX_JUMPS_DEF);
        send_packet();
        // reserved label types
        start_reply(16'h8180, 1, 1);
        pkt.push_back(8'h41);
        pkt.push_back(8'h00);
        send_packet();
        start_reply(16'h8180, 1, 1);
        pkt.push_back(8'h81);
        pkt.push_back(8'h00);
        send_packet();
        // name length right at the limit, then one over
        long_question(31, 31);
        send_packet();
        long_question(31, 32);
        send_packet();
        // truncated record data
        start_reply(16'h8180, 1, 1);
        push_question();
        push16(16'hC00C);
        push_record(TYPE_AAAA, CLASS_IN, RDLEN_AAAA);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_packet();
        // more matches than slots
        start_reply(16'h8180, 1, 6);
        push_question();
        repeat (6)
        begin
            push16(16'hC00C);
            push_record(TYPE_A, CLASS_IN, RDLEN_A);
        end
        send_packet();
        // only non-IN answers
        start_reply(16'h8180, 1, 1);
        push_question();
        push16(16'hC00C);
        push_record(TYPE_A, 3, RDLEN_A);
        send_packet();
        // label running past the end
        start_reply(16'h8180, 1, 1);
        push_label(5);
        pkt.push_back(8'd50);
        pkt.push_back(8'h61);
        send_packet();
    endtask

    function int get_an();
        return (int'(pkt[6]) << 8) | int'(pkt[7]);
    endfunction

    task random_packet();
        int r, at;
        start_reply(($urandom_range(99) < 90) ? 16'h8180 | ($urandom & 16'h7FF0) : $urandom,
                    ($urandom_range(99) < 95) ? 1 : $urandom_range(0, 2),
                    $urandom_range(1, 6));
        push_question();
        repeat (get_an()) push_rand_answer();
        r = $urandom_range(99);
        if (r < 10)
        begin
            at = $urandom_range(pkt.size() - 1);
            pkt[at] = 8'($urandom);
        end
        else if (r < 18)
        begin
            at = $urandom_range(1, pkt.size());
            while (pkt.size() > at) void'(pkt.pop_back());
        end
        else if (r < 20)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        int rand_bytes, start_bytes, npk;
        sb = new();
        rst_n = 1'b0;
        in_valid <= 1'b0;
        pkt_byte <= 8'h00;
        end_of_packet <= 1'b0;
        calm_in = 0;
        calm_out = 0;
        hold_req = 0;
        bytes_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        rand_bytes = 0;
        npk = 0;
        while (rand_bytes < 420 && npk < 300)
        begin
            calm_in = (npk >= 1 && npk < 3);
            if (npk == 0) hold_req = 1;
            if (npk == 1)
            begin
                // oversize packet: bytes past the buffer are discarded
                pkt.delete();
                repeat (PACKET_BYTES_DEF + 8) pkt.push_back(8'($urandom));
                send_packet();
            end
            random_packet();
            start_bytes = bytes_sent;
            send_packet();
            rand_bytes += bytes_sent - start_bytes;
            npk++;
        end
        calm_in = 0;
        in_valid <= 1'b0;
        end_of_packet <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        $display("%0d packets (%0d usable replies), %0d bytes in, %0d beats matched",
                 sb.packets, sb.good_packets, bytes_sent, sb.matched);
        $display("%0d mismatching or unexpected beats", sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== dns_reply_address_extractor.f =====
rtl/dra_pkg.sv
rtl/dra_ram.sv
rtl/dra_front.sv
rtl/dra_jobq.sv
rtl/dra_back.sv
rtl/dns_reply_address_extractor.sv
bench/tb.sv
